// ===== design/aie_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package aie_pkg;

   localparam int DataWordsDefault = 256;
   localparam int CodeWordsDefault = 4096;

   localparam logic [12:0] CodeLengthReset = 13'd0;
   localparam logic [8:0]  DataCountReset  = 9'd256;

   typedef enum logic [3:0] {
      FUNC_LOAD    = 4'd0,
      FUNC_STORE   = 4'd1,
      FUNC_ADD     = 4'd2,
      FUNC_SUB     = 4'd3,
      FUNC_MULT    = 4'd4,
      FUNC_DIV     = 4'd5,
      FUNC_BRANY   = 4'd6,
      FUNC_BRPOS   = 4'd7,
      FUNC_BRZERO  = 4'd8,
      FUNC_BRNEG   = 4'd9,
      FUNC_SYSCALL = 4'd10
   } func_type;

   localparam logic [3:0] SysFinish = 4'd0;
   localparam logic [3:0] SysPrint  = 4'd1;
   localparam logic [3:0] SysRead   = 4'd2;

   localparam logic [3:0] StNormal     = 4'd0;
   localparam logic [3:0] StFinished   = 4'd1;
   localparam logic [3:0] StPrint      = 4'd2;
   localparam logic [3:0] StRead       = 4'd3;
   localparam logic [3:0] StPcRange    = 4'd4;
   localparam logic [3:0] StDivZero    = 4'd5;
   localparam logic [3:0] StStoreImm   = 4'd6;
   localparam logic [3:0] StBadVar     = 4'd7;
   localparam logic [3:0] StBadSyscall = 4'd8;
   localparam logic [3:0] StBadOpcode  = 4'd9;

   localparam logic CsrCodeLength = 1'b0;
   localparam logic CsrDataCount  = 1'b1;

   typedef enum logic [2:0] {
      OP_LOAD, OP_STORE, OP_ADD, OP_SUB, OP_MULT, OP_DIV, OP_BRANCH, OP_SYS
   } op_type;

   typedef struct packed {
      logic [3:0]  func;
      logic        is_immediate;
      logic [31:0] immediate;
      logic [7:0]  var_index;
      logic [11:0] target_address;
      logic [3:0]  syscall_number;
      logic [31:0] read_value;
   } req_type;

   typedef struct packed {
      logic [3:0]  status;
      logic [31:0] acc_value;
      logic [12:0] pc_value;
   } rsp_type;

   // classified instruction handed from front to back
   typedef struct packed {
      op_type      op;
      logic [3:0]  func;
      logic [3:0]  err;      // nonzero: fixed error status (except pc range)
      logic        is_immediate;
      logic [31:0] immediate;
      logic [7:0]  var_index;
      logic [11:0] target_address;
      logic [3:0]  syscall_number;
      logic [31:0] read_value;
   } ins_type;

endpackage
`default_nettype wire

// ===== design/aie_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module aie_ram #(
   parameter int Width = 32,
   parameter int Depth = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ===== design/aie_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module aie_front #(
   parameter int DataWords = 256
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire aie_pkg::req_type req_word,
   input  wire logic [8:0]      data_count,
   output logic                 q_valid,
   input  wire logic            q_ready,
   output aie_pkg::ins_type     q_word
);
   import aie_pkg::*;

   // two-entry queue
   ins_type    slot_ff [2];
   ins_type    slot_in;
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   logic       push, pop;
   logic       var_ok;

   assign req_ready = (count_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign q_valid   = (count_ff != 2'd0);
   assign pop       = q_valid && q_ready;
   assign q_word    = slot_ff[rd_ptr_ff];

   always_comb begin
      var_ok = ({1'b0, req_word.var_index} < data_count) &&
               ({24'd0, req_word.var_index} < 32'(DataWords));
      slot_in                = '0;
      slot_in.func           = req_word.func;
      slot_in.is_immediate   = req_word.is_immediate;
      slot_in.immediate      = req_word.immediate;
      slot_in.var_index      = req_word.var_index;
      slot_in.target_address = req_word.target_address;
      slot_in.syscall_number = req_word.syscall_number;
      slot_in.read_value     = req_word.read_value;
      slot_in.op             = OP_SYS;
      slot_in.err            = StNormal;
      unique case (req_word.func)
         FUNC_LOAD:  slot_in.op = OP_LOAD;
         FUNC_STORE: slot_in.op = OP_STORE;
         FUNC_ADD:   slot_in.op = OP_ADD;
         FUNC_SUB:   slot_in.op = OP_SUB;
         FUNC_MULT:  slot_in.op = OP_MULT;
         FUNC_DIV:   slot_in.op = OP_DIV;
         FUNC_BRANY, FUNC_BRPOS, FUNC_BRZERO, FUNC_BRNEG: slot_in.op = OP_BRANCH;
         FUNC_SYSCALL: begin
            slot_in.op = OP_SYS;
            if (req_word.syscall_number != SysFinish &&
                req_word.syscall_number != SysPrint &&
                req_word.syscall_number != SysRead) begin
               slot_in.err = StBadSyscall;
            end
         end
         default: slot_in.err = StBadOpcode;
      endcase
      if (req_word.func == FUNC_STORE && req_word.is_immediate) begin
         slot_in.err = StStoreImm;
      end else if ((req_word.func == FUNC_STORE || ((req_word.func == FUNC_LOAD ||
                   req_word.func == FUNC_ADD || req_word.func == FUNC_SUB ||
                   req_word.func == FUNC_MULT || req_word.func == FUNC_DIV) &&
                   !req_word.is_immediate)) && !var_ok) begin
         slot_in.err = StBadVar;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= slot_in;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
   end
endmodule
`default_nettype wire

// ===== design/aie_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
module aie_div (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [31:0] dividend,
   input  wire logic [31:0] divisor,
   output logic             done,
   output logic [31:0]      quotient
);
   logic [31:0] rem_ff, quo_ff, den_ff;
   logic [5:0]  cnt_ff;
   logic        neg_ff, busy_ff, done_ff;
   logic [32:0] trial;
   logic [31:0] rem_sh;

   assign rem_sh   = {rem_ff[30:0], quo_ff[31]};
   assign trial    = {1'b0, rem_sh} - {1'b0, den_ff};
   assign done     = done_ff;
   assign quotient = neg_ff ? (32'd0 - quo_ff) : quo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 6'd0;
      end else begin
         done_ff <= !start && busy_ff && (cnt_ff == 6'd1);
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 6'd32;
            rem_ff  <= 32'd0;
            quo_ff  <= dividend[31] ? (32'd0 - dividend) : dividend;
            den_ff  <= divisor[31] ? (32'd0 - divisor) : divisor;
            neg_ff  <= dividend[31] ^ divisor[31];
         end else if (busy_ff) begin
            if (!trial[32]) begin
               rem_ff <= trial[31:0];
            end else begin
               rem_ff <= rem_sh;
            end
            quo_ff  <= {quo_ff[30:0], ~trial[32]};
            cnt_ff  <= cnt_ff - 6'd1;
            busy_ff <= (cnt_ff != 6'd1);
         end
      end
   end
endmodule
`default_nettype wire

// ===== design/aie_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module aie_back #(
   parameter int DataWords = 256,
   parameter int CodeWords = 4096
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             q_valid,
   output logic                  q_ready,
   input  wire aie_pkg::ins_type q_word,
   input  wire logic [12:0]      code_length,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output aie_pkg::rsp_type      rsp_word
);
   import aie_pkg::*;

   localparam int AddrW = (DataWords > 1) ? $clog2(DataWords) : 1;

   typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_READ, S_EXEC, S_MULT, S_DIV, S_OUT}
      state_type;

   state_type   state_ff;
   ins_type     ins_ff;
   logic [31:0] acc_ff, prod_ff;
   logic [12:0] pc_ff;
   logic [AddrW:0] clr_ff;
   rsp_type     rsp_ff;

   logic             wr_en;
   logic [AddrW-1:0] wr_addr, rd_addr;
   logic [31:0]      wr_data, rd_data, opv;
   logic             div_start, div_done;
   logic [31:0]      div_q;
   logic [12:0]      next_pc;
   logic             pc_bad, jump;
   state_type        state_in;
   logic [3:0]       status_in;
   logic [31:0]      acc_in;
   logic [12:0]      pc_in;

   aie_ram #(.Width(32), .Depth(DataWords)) u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   aie_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(acc_ff),
      .divisor(opv), .done(div_done), .quotient(div_q)
   );

   assign q_ready   = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);
   assign rsp_word  = rsp_ff;
   assign rd_addr   = AddrW'(q_word.var_index);
   assign opv       = ins_ff.is_immediate ? ins_ff.immediate : rd_data;
   assign next_pc   = pc_ff + 13'd1;
   assign pc_bad    = (pc_ff >= code_length) || ({19'd0, pc_ff} >= 32'(CodeWords));
   assign div_start = (state_ff == S_EXEC) && (ins_ff.op == OP_DIV) && !pc_bad &&
                      (ins_ff.err == StNormal) && (opv != 32'd0);

   always_comb begin
      unique case (ins_ff.func)
         FUNC_BRANY:  jump = 1'b1;
         FUNC_BRPOS:  jump = (acc_ff != 32'd0) && !acc_ff[31];
         FUNC_BRZERO: jump = (acc_ff == 32'd0);
         default:     jump = acc_ff[31];
      endcase
      wr_en   = 1'b0;
      wr_addr = AddrW'(ins_ff.var_index);
      wr_data = acc_ff;
      if (state_ff == S_CLEAR) begin
         wr_en   = 1'b1;
         wr_addr = clr_ff[AddrW-1:0];
         wr_data = 32'd0;
      end else if (state_ff == S_EXEC && ins_ff.op == OP_STORE && !pc_bad &&
                   ins_ff.err == StNormal) begin
         wr_en = 1'b1;
      end
   end

   always_comb begin
      state_in  = S_OUT;
      status_in = StNormal;
      acc_in    = acc_ff;
      pc_in     = pc_ff;
      if (pc_bad) begin
         status_in = StPcRange;
      end else if (ins_ff.err != StNormal) begin
         status_in = ins_ff.err;
      end else begin
         unique case (ins_ff.op)
            OP_LOAD: begin
               acc_in = opv; pc_in = next_pc;
            end
            OP_ADD: begin
               acc_in = acc_ff + opv; pc_in = next_pc;
            end
            OP_SUB: begin
               acc_in = acc_ff - opv; pc_in = next_pc;
            end
            OP_STORE: pc_in = next_pc;
            OP_MULT:  state_in = S_MULT;
            OP_DIV: begin
               if (opv == 32'd0) status_in = StDivZero;
               else              state_in = S_DIV;
            end
            OP_BRANCH: pc_in = jump ? {1'b0, ins_ff.target_address} : next_pc;
            default: begin
               if (ins_ff.syscall_number == SysFinish) begin
                  status_in = StFinished;
               end else if (ins_ff.syscall_number == SysPrint) begin
                  status_in = StPrint;
                  pc_in = next_pc;
               end else begin
                  status_in = StRead;
                  acc_in = ins_ff.read_value;
                  pc_in = next_pc;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         acc_ff   <= 32'd0;
         pc_ff    <= 13'd0;
      end else begin
         unique case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == (AddrW+1)'(DataWords - 1)) state_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (q_valid) begin
                  ins_ff   <= q_word;
                  state_ff <= S_EXEC;
               end
            end
            S_READ: state_ff <= S_EXEC;
            S_EXEC: begin
               acc_ff           <= acc_in;
               pc_ff            <= pc_in;
               prod_ff          <= acc_ff * opv;
               rsp_ff.status    <= status_in;
               rsp_ff.acc_value <= acc_in;
               rsp_ff.pc_value  <= pc_in;
               state_ff         <= state_in;
            end
            S_MULT: begin
               acc_ff <= prod_ff; pc_ff <= next_pc;
               rsp_ff.acc_value <= prod_ff; rsp_ff.pc_value <= next_pc;
               state_ff <= S_OUT;
            end
            S_DIV: begin
               if (div_done) begin
                  acc_ff <= div_q; pc_ff <= next_pc;
                  rsp_ff.acc_value <= div_q; rsp_ff.pc_value <= next_pc;
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (rsp_ready) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

// ===== design/accumulator_instruction_execute_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// The back-end sequencer takes a new word only after the last response is
// accepted, and the data RAM's read is registered; div runs a radix-2 loop.
// Reset: synchronous; then a clearing pass zeroes every data RAM word, during
// which no word is executed (config writes still taken).
module accumulator_instruction_execute_top #(
   parameter int DATA_WORDS = aie_pkg::DataWordsDefault,
   parameter int CODE_WORDS = aie_pkg::CodeWordsDefault
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire aie_pkg::req_type req_word,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output aie_pkg::rsp_type      rsp_word,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic             csr_index,
   input  wire logic [12:0]      csr_data
);
   import aie_pkg::*;

   logic [12:0] code_length_ff;
   logic [8:0]  data_count_ff;
   logic        q_valid, q_ready;
   ins_type     q_word;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         code_length_ff <= CodeLengthReset;
         data_count_ff  <= DataCountReset;
      end else if (csr_valid) begin
         if (csr_index == CsrCodeLength) code_length_ff <= csr_data;
         else                            data_count_ff  <= csr_data[8:0];
      end
   end

   aie_front #(.DataWords(DATA_WORDS)) u_front (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .req_word(req_word), .data_count(data_count_ff),
      .q_valid(q_valid), .q_ready(q_ready), .q_word(q_word)
   );

   aie_back #(.DataWords(DATA_WORDS), .CodeWords(CODE_WORDS)) u_back (
      .clock(clock), .reset(reset), .q_valid(q_valid), .q_ready(q_ready),
      .q_word(q_word), .code_length(code_length_ff),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_word(rsp_word)
   );
endmodule
`default_nettype wire

// ===== design/aie_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module aie_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_ready,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire aie_pkg::rsp_type rsp_word
);
   import aie_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
      else $error("rsp dropped");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_word.status <= StBadOpcode)
      else $error("bad status");

   a_no_rsp_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp after reset");

   a_req_ready_known: assert property (@(posedge clock) disable iff (reset)
      req_valid |-> !$isunknown(req_ready))
      else $error("req_ready unknown");
endmodule

bind accumulator_instruction_execute_top aie_checker u_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_word(rsp_word)
);
`default_nettype wire
